### rtl/core/gtl_pkg.sv
`default_nettype none

package gtl_pkg;

    localparam int GRID_MAX_DEF  = 64;
    localparam int FREQ_BITS_DEF = 32;

    localparam int IDX_W       = 9;
    localparam int FREQ_W      = 32;
    localparam int AMP_W       = 16;
    localparam int OFS_W       = 32;
    localparam int SPC_W       = 28;
    localparam int CNT_W       = 7;
    localparam int DIST_W      = IDX_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET     = 3'd0,
        REG_Y_OFFSET     = 3'd1,
        REG_X_SPACING    = 3'd2,
        REG_Y_SPACING    = 3'd3,
        REG_COLUMN_COUNT = 3'd4,
        REG_ROW_COUNT    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] x_offset;
        logic signed [OFS_W-1:0] y_offset;
        logic [SPC_W-1:0]        x_spacing;
        logic [SPC_W-1:0]        y_spacing;
        logic [CNT_W-1:0]        column_count;
        logic [CNT_W-1:0]        row_count;
    } cfg_t;

    // One decoded item as it travels from the front to the back.
    typedef struct packed {
        logic                     is_write;
        logic                     axis;
        logic [CNT_W-1:0]         col;
        logic [CNT_W-1:0]         row;
        logic signed [DIST_W-1:0] span;
        logic [FREQ_W-1:0]        freq_word;
        logic [AMP_W-1:0]         amp_word;
    } op_t;

endpackage

`default_nettype wire

### rtl/core/gtl_item_if.sv
`default_nettype none

interface gtl_item_if import gtl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [IDX_W-1:0] x_index;
    logic signed [IDX_W-1:0] y_index;
    logic                    axis;
    logic [FREQ_W-1:0]       freq_word;
    logic [AMP_W-1:0]        amp_word;

    modport source (
        output valid, command, x_index, y_index, axis, freq_word, amp_word,
        input  ready
    );

    modport sink (
        input  valid, command, x_index, y_index, axis, freq_word, amp_word,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/gtl_result_if.sv
`default_nettype none

interface gtl_result_if import gtl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_out;
    logic [AMP_W-1:0]  amp_out;
    logic              saturated;

    modport source (
        output valid, freq_out, amp_out, saturated,
        input  ready
    );

    modport sink (
        input  valid, freq_out, amp_out, saturated,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/gtl_cfg_if.sv
`default_nettype none

interface gtl_cfg_if import gtl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/gtl_cfg.sv
`default_nettype none

module gtl_cfg import gtl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gtl_cfg_if.sink    cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.x_offset     <= '0;
            regs_reg.y_offset     <= '0;
            regs_reg.x_spacing    <= '0;
            regs_reg.y_spacing    <= '0;
            regs_reg.column_count <= COUNT_RESET;
            regs_reg.row_count    <= COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_X_OFFSET:     regs_reg.x_offset     <= cfg.data[OFS_W-1:0];
                REG_Y_OFFSET:     regs_reg.y_offset     <= cfg.data[OFS_W-1:0];
                REG_X_SPACING:    regs_reg.x_spacing    <= cfg.data[SPC_W-1:0];
                REG_Y_SPACING:    regs_reg.y_spacing    <= cfg.data[SPC_W-1:0];
                REG_COLUMN_COUNT: regs_reg.column_count <= cfg.data[CNT_W-1:0];
                REG_ROW_COUNT:    regs_reg.row_count    <= cfg.data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/gtl_front.sv
`default_nettype none

module gtl_front import gtl_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF
)
(
    gtl_item_if.sink   item,
    input  cfg_t       regs,
    input  logic       q_ready,
    output logic       q_push,
    output op_t        q_op
);

    localparam logic [CNT_W-1:0] GRID_LIM = CNT_W'(GRID_MAX);

    logic [CNT_W-1:0]         cols;
    logic [CNT_W-1:0]         rows;
    logic [CNT_W-1:0]         last_col;
    logic [CNT_W-1:0]         last_row;
    logic signed [DIST_W-1:0] xs;
    logic signed [DIST_W-1:0] ys;
    logic signed [DIST_W-1:0] cols_s;
    logic signed [DIST_W-1:0] rows_s;
    logic signed [DIST_W-1:0] last_col_s;
    logic signed [DIST_W-1:0] last_row_s;
    logic                     x_lo;
    logic                     x_hi;
    logic                     y_lo;
    logic                     y_hi;
    logic                     in_grid;
    logic                     is_write;

    // count of zero acts as one, anything above the grid as the grid size
    always_comb
    begin
        if (regs.column_count == '0)
            cols = CNT_W'(1);
        else if (regs.column_count > GRID_LIM)
            cols = GRID_LIM;
        else
            cols = regs.column_count;

        if (regs.row_count == '0)
            rows = CNT_W'(1);
        else if (regs.row_count > GRID_LIM)
            rows = GRID_LIM;
        else
            rows = regs.row_count;
    end

    assign last_col   = cols - CNT_W'(1);
    assign last_row   = rows - CNT_W'(1);
    assign xs         = {item.x_index[IDX_W-1], item.x_index};
    assign ys         = {item.y_index[IDX_W-1], item.y_index};
    assign cols_s     = {{(DIST_W-CNT_W){1'b0}}, cols};
    assign rows_s     = {{(DIST_W-CNT_W){1'b0}}, rows};
    assign last_col_s = {{(DIST_W-CNT_W){1'b0}}, last_col};
    assign last_row_s = {{(DIST_W-CNT_W){1'b0}}, last_row};

    assign x_lo     = xs[DIST_W-1];
    assign x_hi     = xs >= cols_s;
    assign y_lo     = ys[DIST_W-1];
    assign y_hi     = ys >= rows_s;
    assign in_grid  = !x_lo && !x_hi && !y_lo && !y_hi;
    assign is_write = (item.command == CMD_WRITE);

    // Frequency and amplitude both read the cell at the clamped indices;
    // only the extrapolation distance differs by axis.
    always_comb
    begin
        q_op.is_write  = is_write;
        q_op.axis      = item.axis;
        q_op.col       = x_lo ? '0 : (x_hi ? last_col : item.x_index[CNT_W-1:0]);
        q_op.row       = y_lo ? '0 : (y_hi ? last_row : item.y_index[CNT_W-1:0]);
        q_op.freq_word = item.freq_word;
        q_op.amp_word  = item.amp_word;
        if (item.axis == AXIS_X)
            q_op.span = x_lo ? -xs : (x_hi ? (last_col_s - xs) : '0);
        else
            q_op.span = y_lo ? ys : (y_hi ? (ys - last_row_s) : '0);
    end

    // writes outside the grid are taken and dropped here
    assign item.ready = q_ready;
    assign q_push     = item.valid && q_ready && (!is_write || in_grid);

endmodule

`default_nettype wire

### rtl/core/gtl_fifo.sv
`default_nettype none

module gtl_fifo import gtl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic in_ready,
    output logic out_valid,
    output op_t  out_op,
    input  logic pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W_Q = PTR_W + 1;
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(QUEUE_DEPTH);

    op_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg;
    logic [CNT_W_Q-1:0] count_next;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W_Q'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W_Q'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

### rtl/core/gtl_back.sv
`default_nettype none

module gtl_back import gtl_pkg::*;
#(
    parameter int GRID_MAX  = GRID_MAX_DEF,
    parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         regs,
    input  logic         q_valid,
    input  op_t          q_op,
    output logic         q_pop,
    gtl_result_if.source result
);

    localparam int STORE_DEPTH = 2 * GRID_MAX * GRID_MAX;
    localparam int CELL_W      = $clog2(GRID_MAX * GRID_MAX);
    localparam int ADDR_W      = CELL_W + 1;
    localparam int PROD_W      = DIST_W + SPC_W + 1;
    localparam int SUM_W       = (FREQ_BITS + 2 > PROD_W + 1) ? FREQ_BITS + 2 : PROD_W + 1;
    localparam logic [SUM_W-1:0] FMAX = {{(SUM_W-FREQ_BITS){1'b0}}, {FREQ_BITS{1'b1}}};

    logic [FREQ_W-1:0] freq_mem [STORE_DEPTH];
    logic [AMP_W-1:0]  amp_mem  [STORE_DEPTH];

    logic [CELL_W-1:0]        grid_pos;
    logic [ADDR_W-1:0]        mem_addr;
    logic signed [DIST_W-1:0] dist_s;
    logic signed [SPC_W:0]    spc_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [OFS_W-1:0]  ofs;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [FREQ_W-1:0]        s1_freq_reg;
    logic [AMP_W-1:0]         s1_amp_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic signed [OFS_W-1:0]  s1_ofs_reg;

    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    logic signed [SUM_W-1:0]  s2_sum_reg;
    logic [AMP_W-1:0]         s2_amp_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [FREQ_W-1:0]        out_freq_reg;
    logic [AMP_W-1:0]         out_amp_reg;
    logic                     out_sat_reg;

    logic                     out_free;
    logic                     s2_free;
    logic                     s1_free;

    logic signed [SUM_W-1:0]  freq_ext;
    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  ofs_ext;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         sum_u;
    logic                     sum_neg;
    logic                     sum_over;
    logic [SUM_W-1:0]         freq_sat;

    // pipeline advance, back from the output register
    assign out_free = !out_valid_reg || result.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign q_pop    = q_valid && s1_free;

    // stage 1: table access and spacing product
    assign grid_pos = CELL_W'(q_op.row) * CELL_W'(GRID_MAX) + CELL_W'(q_op.col);
    assign mem_addr = {grid_pos, q_op.axis};
    assign dist_s   = q_op.span;
    assign spc_s    = {1'b0, (q_op.axis == AXIS_Y) ? regs.y_spacing : regs.x_spacing};
    assign prod     = dist_s * spc_s;
    assign ofs      = (q_op.axis == AXIS_Y) ? regs.y_offset : regs.x_offset;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_op.is_write)
            begin
                freq_mem[mem_addr] <= q_op.freq_word;
                amp_mem[mem_addr]  <= q_op.amp_word;
            end
            s1_freq_reg <= freq_mem[mem_addr];
            s1_amp_reg  <= amp_mem[mem_addr];
        end
    end

    // stage 2: table value plus distance term plus offset
    assign freq_ext = {{(SUM_W-FREQ_W){1'b0}}, s1_freq_reg};
    assign prod_ext = SUM_W'(s1_prod_reg);
    assign ofs_ext  = SUM_W'(s1_ofs_reg);
    assign sum_next = freq_ext + prod_ext + ofs_ext;

    // output stage: clip to the frequency range
    assign sum_u    = s2_sum_reg;
    assign sum_neg  = s2_sum_reg[SUM_W-1];
    assign sum_over = !sum_neg && (sum_u > FMAX);
    assign freq_sat = sum_neg ? '0 : (sum_over ? FMAX : sum_u);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
            s1_valid_next = !q_op.is_write;
        else if (s2_free)
            s1_valid_next = 1'b0;
        if (s2_free)
            s2_valid_next = s1_valid_reg;
        if (out_free)
            out_valid_next = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_prod_reg <= prod;
            s1_ofs_reg  <= ofs;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_sum_reg <= sum_next;
            s2_amp_reg <= s1_amp_reg;
        end
        if (out_free && s2_valid_reg)
        begin
            out_freq_reg <= freq_sat[FREQ_W-1:0];
            out_amp_reg  <= s2_amp_reg;
            out_sat_reg  <= sum_neg || sum_over;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.freq_out  = out_freq_reg;
    assign result.amp_out   = out_amp_reg;
    assign result.saturated = out_sat_reg;

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            (result.freq_out == '0 || result.freq_out == FMAX[FREQ_W-1:0]))
        else $error("saturated result is not a range limit");

    a_no_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |-> !q_pop)
        else $error("queue popped into a stalled stage");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_op.is_write |=> !s1_valid_reg)
        else $error("write item entered the result pipeline");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_free |=> s2_valid_reg)
        else $error("stalled sum stage lost its item");

endmodule

`default_nettype wire

### rtl/core/grid_tone_lut_extrapolate.sv
`default_nettype none

// Tone table for a 2D grid of cells, each holding an X and a Y tone (frequency Q8.24 MHz,
// amplitude Q0.16). A write item stores one axis entry of one cell; writes outside the
// grid in use are dropped without a result. A lookup item returns one result: the
// amplitude at the clamped indices, and the frequency read at the clamped indices or
// extrapolated from the edge cell by the axis spacing (X falls, Y rises with its index),
// plus the axis offset, clipped to [0, 2^FREQ_BITS - 1] with saturated set on a clip.
// Items are taken at one per cycle sustained while the result output is not stalled: the
// front decodes an item in the cycle it is accepted into a four-entry queue, the back
// does one table access per cycle on each single-port store, then the sum and the clip.
// A lookup result passes the queue and the stage 1, sum and output registers before it
// is presented. Writes land in the table in order, so a later lookup sees them. Table
// contents are undefined until written; there is no clearing pass after reset. The user
// ensures configuration registers are written while no item is in flight; not enforced.
module grid_tone_lut_extrapolate import gtl_pkg::*;
#(
    parameter int GRID_MAX  = GRID_MAX_DEF,
    parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    gtl_item_if.sink     item,
    gtl_result_if.source result,
    gtl_cfg_if.sink      cfg
);

    cfg_t regs;
    logic q_ready;
    logic q_push;
    op_t  q_push_op;
    logic q_valid;
    op_t  q_op;
    logic q_pop;

    gtl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    gtl_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .item    (item),
        .regs    (regs),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_op    (q_push_op)
    );

    gtl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_push_op),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_op    (q_op),
        .pop       (q_pop)
    );

    gtl_back #(
        .GRID_MAX  (GRID_MAX),
        .FREQ_BITS (FREQ_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire
